FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

// condition in one cycle implies a consequence in the next
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle property");

`endif

FILE: rtl/cagr_pkg.sv
// ----------------------------------------------------------------------------
// cagr_pkg
// types, codes and command/status structs of the call-aware reachability unit
// ----------------------------------------------------------------------------
package cagr_pkg;

    localparam int CAGR_MAX_VERTICES = 64;
    localparam int VERTEX_W          = 6;
    localparam int COUNT_W           = 7;
    localparam int MAX_COUNT         = 1 << VERTEX_W;

    typedef enum logic [1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_REACH   = 2'd1,
        FUNC_CLOSURE = 2'd2
    } func_t;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_PLAIN  = 2'd1;
    localparam logic [1:0] KIND_CALL   = 2'd2;
    localparam logic [1:0] KIND_RETURN = 2'd3;

    typedef struct packed {
        logic [1:0]          func;
        logic [VERTEX_W-1:0] src;
        logic [VERTEX_W-1:0] dst;
        logic [1:0]          kind;
    } item_t;

    typedef struct packed {
        logic               reached;
        logic [COUNT_W-1:0] closure_count;
    } result_t;

    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_ONE   = 2'd1,
        RES_REACH = 2'd2,
        RES_COUNT = 2'd3
    } res_sel_t;

    typedef struct packed {
        logic     load_item;
        logic     clr_wr;
        logic     wr_edge;
        logic     seen_init;
        logic     sweep_issue;
        logic     changed_clr;
        logic     cnt_clear;
        logic     cnt_step;
        logic     count_step;
        logic     load_result;
        res_sel_t res_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_is_write;
        logic in_is_reach;
        logic in_is_closure;
        logic in_src_ok;
        logic in_dst_ok;
        logic in_same;
        logic cnt_last;
        logic changed;
        logic item_closure;
    } dp_status_t;

endpackage

FILE: rtl/cagr_ram.sv
// ----------------------------------------------------------------------------
// cagr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cagr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/cagr_ctrl.sv
// ----------------------------------------------------------------------------
// cagr_ctrl
// sequencer: clearing pass, edge writes, frontier sweeps, counting, result
// ----------------------------------------------------------------------------
module cagr_ctrl
    import cagr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    output logic       result_valid,
    input  logic       result_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_WRITE = 7'b0000100,
        ST_SWEEP = 7'b0001000,
        ST_TAIL  = 7'b0010000,
        ST_COUNT = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t   state_reg, state_next;
    res_sel_t res_reg, res_next;
    logic     out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && result_stall;
        cmd            = '0;
        cmd.res_sel    = res_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr   = 1'b1;
                cmd.cnt_step = 1'b1;
                if (status.cnt_last)
                begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    res_next      = RES_ZERO;
                    state_next    = ST_DONE;
                    if (status.in_is_write)
                    begin
                        if (status.in_src_ok && status.in_dst_ok)
                        begin
                            state_next = ST_WRITE;
                        end
                    end
                    else if (status.in_is_reach || status.in_is_closure)
                    begin
                        if (status.in_src_ok)
                        begin
                            if (status.in_is_reach && status.in_same)
                            begin
                                res_next = RES_ONE;
                            end
                            else
                            begin
                                cmd.seen_init = 1'b1;
                                cmd.cnt_clear = 1'b1;
                                state_next    = ST_SWEEP;
                            end
                        end
                    end
                end
            end
            ST_WRITE:
            begin
                // read of the row landed this cycle, write it back modified
                cmd.wr_edge = 1'b1;
                state_next  = ST_DONE;
            end
            ST_SWEEP:
            begin
                cmd.sweep_issue = 1'b1;
                cmd.cnt_step    = 1'b1;
                if (status.cnt_last)
                begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                cmd.changed_clr = 1'b1;
                if (status.changed)
                begin
                    state_next = ST_SWEEP;
                end
                else if (status.item_closure)
                begin
                    state_next = ST_COUNT;
                end
                else
                begin
                    res_next   = RES_REACH;
                    state_next = ST_DONE;
                end
            end
            ST_COUNT:
            begin
                cmd.count_step = 1'b1;
                cmd.cnt_step   = 1'b1;
                if (status.cnt_last)
                begin
                    cmd.cnt_clear = 1'b1;
                    res_next      = RES_COUNT;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            res_reg       <= RES_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;

endmodule

FILE: rtl/cagr_dpath.sv
// ----------------------------------------------------------------------------
// cagr_dpath
// adjacency ram, visited marks, sweep counter, row update and result register
// ----------------------------------------------------------------------------
module cagr_dpath
    import cagr_pkg::*;
#(
    parameter int MAX_VERTICES = CAGR_MAX_VERTICES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      item,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    output result_t    result
);

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int RW = 2 * MAX_VERTICES;
    localparam logic [VW-1:0] LAST_IDX = VW'(MAX_VERTICES - 1);

    item_t                 item_reg;
    result_t               result_reg, result_next;
    logic [VW-1:0]         cnt_reg, cnt_next;
    logic                  proc_reg;
    logic [VW-1:0]         row_d_reg;
    logic [MAX_VERTICES-1:0] outer_reg, outer_next;
    logic [MAX_VERTICES-1:0] body_reg, body_next;
    logic                  changed_reg, changed_next;
    logic [COUNT_W-1:0]    count_reg, count_next;

    logic [RW-1:0]         rd_row, row_mod, wdata;
    logic [VW-1:0]         raddr, waddr;
    logic [VW-1:0]         src_in_idx, src_idx, dst_idx;
    logic [1:0]            kinds [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] add_o, add_b;
    logic                  change_now;
    logic                  dst_ok, reach_hit;

    assign src_in_idx = VW'(item.src);
    assign src_idx    = VW'(item_reg.src);
    assign dst_idx    = VW'(item_reg.dst);

    // ram ports
    assign raddr = cmd.sweep_issue ? cnt_reg : src_in_idx;
    assign waddr = cmd.clr_wr ? cnt_reg : src_idx;
    assign wdata = cmd.clr_wr ? '0 : row_mod;

    cagr_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_VERTICES)
    ) u_adj (
        .clk   (clk),
        .we    (cmd.clr_wr || cmd.wr_edge),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_row)
    );

    // replace one edge kind in the fetched row
    always_comb
    begin
        row_mod = rd_row;
        row_mod[{dst_idx, 1'b0} +: 2] = item_reg.kind;
    end

    // relax all edges of one row against the current marks
    always_comb
    begin
        add_o = '0;
        add_b = '0;
        for (int v = 0; v < MAX_VERTICES; v++)
        begin
            kinds[v] = rd_row[2*v +: 2];
            if (proc_reg)
            begin
                if (outer_reg[row_d_reg])
                begin
                    if (kinds[v] == KIND_CALL)
                    begin
                        add_b[v] = 1'b1;
                    end
                    else if (kinds[v] != KIND_NONE)
                    begin
                        add_o[v] = 1'b1;
                    end
                end
                if (body_reg[row_d_reg] && (kinds[v] inside {KIND_PLAIN, KIND_CALL}))
                begin
                    add_b[v] = 1'b1;
                end
            end
        end
    end

    assign change_now = (|(add_o & ~outer_reg)) || (|(add_b & ~body_reg));

    always_comb
    begin
        if (cmd.seen_init)
        begin
            outer_next             = '0;
            outer_next[src_in_idx] = 1'b1;
            body_next              = '0;
        end
        else
        begin
            outer_next = outer_reg | add_o;
            body_next  = body_reg | add_b;
        end
    end

    assign changed_next = (cmd.seen_init || cmd.changed_clr) ? 1'b0
                                                             : (changed_reg || change_now);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clear)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_step)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.seen_init)
        begin
            count_next = '0;
        end
        else if (cmd.count_step)
        begin
            count_next = count_reg + COUNT_W'(outer_reg[cnt_reg] | body_reg[cnt_reg]);
        end
    end

    assign dst_ok    = (32'(item_reg.dst) < MAX_VERTICES);
    assign reach_hit = dst_ok && (outer_reg[dst_idx] || body_reg[dst_idx]);

    always_comb
    begin
        result_next = result_reg;
        if (cmd.load_result)
        begin
            result_next = '0;
            case (cmd.res_sel)
                RES_ZERO:  result_next = '0;
                RES_ONE:   result_next.reached = 1'b1;
                RES_REACH: result_next.reached = reach_hit;
                RES_COUNT: result_next.closure_count = count_reg;
                default:   result_next = '0;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            proc_reg    <= 1'b0;
            changed_reg <= 1'b0;
            outer_reg   <= '0;
            body_reg    <= '0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            proc_reg    <= cmd.sweep_issue;
            changed_reg <= changed_next;
            outer_reg   <= outer_next;
            body_reg    <= body_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        row_d_reg  <= cnt_reg;
        count_reg  <= count_next;
        result_reg <= result_next;
    end

    assign status.in_is_write   = (item.func == FUNC_WRITE);
    assign status.in_is_reach   = (item.func == FUNC_REACH);
    assign status.in_is_closure = (item.func == FUNC_CLOSURE);
    assign status.in_src_ok     = (32'(item.src) < MAX_VERTICES);
    assign status.in_dst_ok     = (32'(item.dst) < MAX_VERTICES);
    assign status.in_same       = (item.src == item.dst);
    assign status.cnt_last      = (cnt_reg == LAST_IDX);
    assign status.changed       = changed_reg || change_now;
    assign status.item_closure  = (item_reg.func == FUNC_CLOSURE);

    assign result = result_reg;

endmodule

FILE: rtl/call_aware_graph_reachability_unit.sv
// ----------------------------------------------------------------------------
// call_aware_graph_reachability_unit
// Holds a directed graph of MAX_VERTICES vertices, one edge kind (none, plain,
// call, return) per ordered pair, one adjacency row per source vertex in a
// ram with one read and one write port. A transaction writes one edge kind or
// runs a query from a start vertex: outer mode follows plain and return edges
// and steps into body mode over call edges; body mode follows plain and call
// edges only. Each transaction gives exactly one result. After reset a
// clearing pass zeroes every row of the ram and no transaction is taken until
// it is over. With N = MAX_VERTICES: an edge write reads the row, writes it
// back modified and then loads the result. A query runs R frontier sweeps,
// one ram row read per cycle, until a sweep adds no new mark (R is at most
// 2N, usually the depth of the search plus one); a closure query then counts
// the marks one vertex a cycle. Acceptance and the result load are steps of
// their own. A reach query whose start equals its target, and any item whose
// source (or, for a write, destination) is outside the graph, goes straight
// from acceptance to the result load. The single ram read port sets the sweep
// length. Input is taken whenever the sequencer is idle, even while a result
// still waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module call_aware_graph_reachability_unit
    import cagr_pkg::*;
#(
    parameter int MAX_VERTICES = CAGR_MAX_VERTICES
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    // command and status between sequencer and datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: clearing pass, write, sweeps, count, result hand-off
    cagr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // adjacency ram, visited marks and result register
    cagr_dpath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    // an accepted transaction leaves the sequencer busy in the next cycle
    `ASSERT_NEXT(a_accept_then_busy, item_valid && !item_stall, item_stall)
    // a result carries at most one non-zero field
    `ASSERT_ALWAYS(a_single_answer, !(result_valid && result.reached && (result.closure_count != '0)))
    // no more distinct vertices than the field can address
    `ASSERT_ALWAYS(a_count_bound, !result_valid || (result.closure_count <= COUNT_W'(MAX_COUNT)))
    // the ram is never written while a sweep reads it
    `ASSERT_ALWAYS(a_ram_exclusive, !((cmd.clr_wr || cmd.wr_edge) && cmd.sweep_issue))

endmodule
